FILE: rtl/core/psb_pkg.sv
package psb_pkg;

  localparam int MAX_LIMIT = 1023;
  localparam int WORD_BITS = 64;

  localparam int LIMIT_W = $clog2(MAX_LIMIT + 1);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int DEPTH   = (MAX_LIMIT + WORD_BITS) / WORD_BITS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // outer index never needs to pass sqrt(limit)+1
  localparam int ROOT_W  = (LIMIT_W + 1) / 2 + 1;
  localparam int NUM_W   = LIMIT_W + 1;

  localparam int OUT_IDX_W = 4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] word_index;
    word_t                prime_bits;
    logic                 last_word;
  } out_word_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [NUM_W-1:0] num);
    addr_of = ADDR_W'(num >> BIT_W);
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [NUM_W-1:0] num);
    bit_of = num[BIT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/prime_sieve_bitmap_unit.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid, in_ready   | limit
// out     | output    | out_valid, out_ready | word_index, prime_bits, last_word
//
// one request presets the bitmap up to limit, tests each i of 2..sqrt(limit)
// with a read and a check state, clears each multiple with a read and a write
// state, then reads out each word with a read and a load state; the single-port
// 16x64 bitmap memory sets the pace. in_ready is high only while idle.
// out words wait in an output register; a stalled out channel halts readout.
// reset returns the sequencer to idle; bitmap contents are not cleared.
module prime_sieve_bitmap_unit
  import psb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LIMIT_W-1:0]   limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] word_index,
  output logic [WORD_BITS-1:0] prime_bits,
  output logic                 last_word
);

  logic              idle;
  logic              out_load;
  out_word_t         out_word;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  word_t             mem_wdata;
  word_t             mem_rdata;

  psb_sieve u_sieve (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid),
    .limit     (limit),
    .idle      (idle),
    .out_busy  (out_valid && !out_ready),
    .out_load  (out_load),
    .out_word  (out_word),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  psb_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign in_ready = idle;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      word_index <= out_word.word_index;
      prime_bits <= out_word.prime_bits;
      last_word  <= out_word.last_word;
    end
  end

endmodule

FILE: rtl/core/psb_ram.sv
module psb_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/psb_sieve.sv
module psb_sieve
  import psb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LIMIT_W-1:0] limit,
  output logic               idle,
  input  logic               out_busy,
  output logic               out_load,
  output out_word_t          out_word,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_addr,
  output word_t              mem_wdata,
  input  word_t              mem_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_CHK_RD = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_MRK_RD = 3'd4;
  localparam logic [2:0] S_MRK_WR = 3'd5;
  localparam logic [2:0] S_OUT_RD = 3'd6;
  localparam logic [2:0] S_OUT_LD = 3'd7;

  logic [2:0]         state, state_next;
  logic [LIMIT_W-1:0] lim, lim_next;
  logic [ADDR_W-1:0]  w, w_next;
  logic [ROOT_W-1:0]  i, i_next;
  logic [NUM_W-1:0]   sq, sq_next;
  logic [NUM_W-1:0]   j, j_next;

  logic [NUM_W-1:0]   lim_x;
  logic [ADDR_W-1:0]  lim_word;
  logic [BIT_W-1:0]   lim_bit;
  logic [ROOT_W-1:0]  i_adv;
  logic [NUM_W-1:0]   sq_adv;
  logic [NUM_W-1:0]   j_adv;
  logic [NUM_W-1:0]   i_x;
  word_t              init_word;

  assign lim_x    = NUM_W'(lim);
  assign lim_word = addr_of(lim_x);
  assign lim_bit  = bit_of(lim_x);
  assign i_x      = NUM_W'(i);
  assign i_adv    = i + ROOT_W'(1);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_adv   = sq + NUM_W'({i, 1'b1});
  assign j_adv    = j + i_x;

  always_comb begin
    init_word = '1;
    if (w == lim_word) begin
      init_word = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - lim_bit);
    end
    if (w == '0) begin
      init_word[1:0] = 2'b00;
    end
  end

  always_comb begin
    state_next = state;
    lim_next   = lim;
    w_next     = w;
    i_next     = i;
    sq_next    = sq;
    j_next     = j;
    mem_we     = 1'b0;
    mem_addr   = w;
    mem_wdata  = init_word;
    out_load   = 1'b0;
    out_word.word_index = OUT_IDX_W'(w);
    out_word.prime_bits = mem_rdata;
    out_word.last_word  = (w == lim_word);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          lim_next   = limit;
          w_next     = '0;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        mem_we = 1'b1;
        if (w == lim_word) begin
          i_next  = ROOT_W'(2);
          sq_next = NUM_W'(4);
          w_next  = '0;
          state_next = (NUM_W'(4) > lim_x) ? S_OUT_RD : S_CHK_RD;
        end else begin
          w_next = w + ADDR_W'(1);
        end
      end
      S_CHK_RD: begin
        mem_addr   = addr_of(i_x);
        state_next = S_CHK;
      end
      S_CHK: begin
        mem_addr = addr_of(i_x);
        if (mem_rdata[bit_of(i_x)]) begin
          j_next     = sq;
          state_next = S_MRK_RD;
        end else begin
          i_next     = i_adv;
          sq_next    = sq_adv;
          state_next = (sq_adv > lim_x) ? S_OUT_RD : S_CHK_RD;
        end
      end
      S_MRK_RD: begin
        mem_addr   = addr_of(j);
        state_next = S_MRK_WR;
      end
      S_MRK_WR: begin
        // read data of j's word is valid now; clear its bit and write back
        mem_we    = 1'b1;
        mem_addr  = addr_of(j);
        mem_wdata = mem_rdata & ~(word_t'(1) << bit_of(j));
        if (j_adv > lim_x) begin
          i_next     = i_adv;
          sq_next    = sq_adv;
          state_next = (sq_adv > lim_x) ? S_OUT_RD : S_CHK_RD;
        end else begin
          j_next     = j_adv;
          state_next = S_MRK_RD;
        end
      end
      S_OUT_RD: begin
        if (!out_busy) begin
          state_next = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_load = 1'b1;
        if (w == lim_word) begin
          state_next = S_IDLE;
        end else begin
          w_next     = w + ADDR_W'(1);
          state_next = S_OUT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    lim <= lim_next;
    w   <= w_next;
    i   <= i_next;
    sq  <= sq_next;
    j   <= j_next;
  end

endmodule

FILE: rtl/core/psb_checker.sv
module psb_checker
  import psb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_IDX_W-1:0] word_index,
  input logic [WORD_BITS-1:0] prime_bits,
  input logic                 last_word
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prime_bits)
      && $stable(word_index) && $stable(last_word))
    else $error("stalled output word changed");

  // a new request is never taken right after one starts
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while sieve busy");

  // 0 and 1 are never prime
  a_low_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_index == '0 |-> prime_bits[1:0] == 2'b00)
    else $error("0 or 1 flagged prime");

  // a word presented right after a non-final word is taken carries the next index
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      !out_valid || word_index == $past(word_index) + OUT_IDX_W'(1))
    else $error("word index out of sequence");

endmodule

bind prime_sieve_bitmap_unit psb_checker u_psb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word_index (word_index),
  .prime_bits (prime_bits),
  .last_word  (last_word)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

class sieve_scoreboard;
  localparam int WORD_CAP = 1 << psb_pkg::OUT_IDX_W;

  psb_pkg::out_word_t pending_words[$];
  int fails;

  function new();
    fails = 0;
  endfunction

  function int pending();
    return pending_words.size();
  endfunction

  task report(string msg);
    $display("[%0t] word check: %s", $realtime, msg);
    fails++;
  endtask

  // sieve 0..limit and queue the bitmap words it should produce
  function void note_limit(logic [psb_pkg::LIMIT_W-1:0] lim_in);
    int unsigned lim, n_words, w, k, i, j, num;
    bit is_prime [0:psb_pkg::MAX_LIMIT];
    psb_pkg::out_word_t wd;
    lim = lim_in;
    if (lim > psb_pkg::MAX_LIMIT) lim = psb_pkg::MAX_LIMIT;
    for (i = 0; i <= lim; i++) is_prime[i] = 1'b1;
    is_prime[0] = 1'b0;
    if (lim >= 1) is_prime[1] = 1'b0;
    for (i = 2; i * i <= lim; i++) begin
      if (is_prime[i]) begin
        for (j = i * i; j <= lim; j += i) is_prime[j] = 1'b0;
      end
    end
    n_words = lim / psb_pkg::WORD_BITS + 1;
    if (n_words > WORD_CAP) n_words = WORD_CAP;
    for (w = 0; w < n_words; w++) begin
      wd.word_index = psb_pkg::OUT_IDX_W'(w);
      wd.prime_bits = '0;
      for (k = 0; k < psb_pkg::WORD_BITS; k++) begin
        num = w * psb_pkg::WORD_BITS + k;
        if (num <= lim && is_prime[num]) wd.prime_bits[k] = 1'b1;
      end
      wd.last_word = (w + 1 == n_words);
      pending_words.push_back(wd);
    end
  endfunction

  task check_word(logic [psb_pkg::OUT_IDX_W-1:0] idx, psb_pkg::word_t bits, logic last);
    psb_pkg::out_word_t exp_w;
    if (pending_words.size() == 0) begin
      report($sformatf("unexpected word index %0d bits %h last %0d", idx, bits, last));
      return;
    end
    exp_w = pending_words.pop_front();
    if (idx !== exp_w.word_index)
      report($sformatf("word_index %0d, want %0d", idx, exp_w.word_index));
    if (bits !== exp_w.prime_bits)
      report($sformatf("word %0d prime_bits %h, want %h", exp_w.word_index, bits,
                       exp_w.prime_bits));
    if (last !== exp_w.last_word)
      report($sformatf("word %0d last_word %0d, want %0d", exp_w.word_index, last,
                       exp_w.last_word));
  endtask
endclass

module tb;
  import psb_pkg::*;

  localparam int IDLE_PCT   = 36;
  localparam int RAND_ITEMS = 200;
  localparam int HOLD_LEN   = 3000;
  localparam int HOLD_AT    = 150;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [LIMIT_W-1:0]   limit;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_IDX_W-1:0] word_index;
  logic [WORD_BITS-1:0] prime_bits;
  logic                 last_word;

  bit calm;
  sieve_scoreboard sb;

  int unsigned directed_limits[] = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 63, 64, 65, 127, 128,
                                     341, 511, 512, 682, 960, 961, 1021, 1022, 1023};

  prime_sieve_bitmap_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .limit(limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_index(word_index),
    .prime_bits(prime_bits),
    .last_word(last_word)
  );

  always #10 clk = ~clk;

  // offer one limit and wait until it is taken
  task send_limit(logic [LIMIT_W-1:0] v);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    limit    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_limit(v);
  endtask

  // receiver: checks each word and drives out_ready
  initial begin
    int words_seen;
    int hold_left;
    bit held;
    words_seen = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_word(word_index, prime_bits, last_word);
        words_seen++;
      end
      if (!held && words_seen >= HOLD_AT) begin
        // long backpressure so the block stalls its input
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int n;
    int unsigned r;
    logic [LIMIT_W-1:0] v;
    rst       = 1'b1;
    in_valid  = 1'b0;
    limit     = '0;
    out_ready = 1'b0;
    calm      = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_limits[i]) send_limit(LIMIT_W'(directed_limits[i]));

    // mostly small limits, the sieve time grows fast with the limit
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == 60) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      calm = (n >= 120 && n < 160);
      r = $urandom_range(99);
      if (r < 70)
        v = LIMIT_W'($urandom_range(127));
      else if (r < 90)
        v = LIMIT_W'($urandom_range(511, 128));
      else
        v = LIMIT_W'($urandom_range(1023, 512));
      send_limit(v);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
